[hdl/itoa_pkg.sv]
// shared types, constants and character functions for the integer to ascii formatter
package itoa_pkg;

   localparam int unsigned CMD_W   = 3;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned BIN_W   = 32;
   localparam int unsigned BCD_W   = 40;

   // conversion commands
   typedef enum logic [CMD_W-1:0] {
      CMD_SDEC = 3'd0,
      CMD_UDEC = 3'd1,
      CMD_HEXL = 3'd2,
      CMD_HEXU = 3'd3,
      CMD_PTR  = 3'd4
   } cmd_type;

   // text that goes ahead of the digits
   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_MINUS,
      PRE_HEX,
      PRE_NIL
   } pre_type;

   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
   localparam logic [CHAR_W-1:0] CH_N     = 8'h6e;
   localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
   localparam logic [CHAR_W-1:0] CH_L     = 8'h6c;
   localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;

   // number of prefix characters, minus one
   function automatic logic [2:0] prefix_last(input pre_type kind);
      logic [2:0] n;
      case (kind)
         PRE_HEX: n = 3'd1;
         PRE_NIL: n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // prefix character at a position
   function automatic logic [CHAR_W-1:0] prefix_char(input pre_type kind, input logic [2:0] idx);
      logic [CHAR_W-1:0] c;
      c = CH_MINUS;
      case (kind)
         PRE_HEX: c = (idx == 3'd0) ? CH_ZERO : CH_X;
         PRE_NIL: begin
            case (idx)
               3'd0:    c = CH_LPAR;
               3'd1:    c = CH_N;
               3'd2:    c = CH_I;
               3'd3:    c = CH_L;
               default: c = CH_RPAR;
            endcase
         end
         default: c = CH_MINUS;
      endcase
      return c;
   endfunction

   // ascii for one digit, decimal or hex
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib, input logic upper);
      logic [CHAR_W-1:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {4'd0, nib};
      end else if (upper) begin
         c = CH_UPA + {4'd0, nib} - 8'd10;
      end else begin
         c = CH_LOWA + {4'd0, nib} - 8'd10;
      end
      return c;
   endfunction

endpackage

[hdl/itoa_if.sv]
// request and response channel interfaces of the formatter
interface itoa_req_if import itoa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink (input valid, input command, input value, output ready);
endinterface

interface itoa_rsp_if import itoa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CHAR_W-1:0]  character;
   logic               last_char;
   logic [COUNT_W-1:0] total_count;

   modport source (output valid, output character, output last_char, output total_count,
                   input ready);
   modport sink (input valid, input character, input last_char, input total_count,
                 output ready);
endinterface

[hdl/itoa_bcd.sv]
// bit-serial binary to bcd converter, shift and add-3, one bit per cycle
module itoa_bcd import itoa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [BIN_W-1:0] bin,
   output logic             done,
   output logic [BCD_W-1:0] bcd
);

   logic [BIN_W-1:0] bin_ff;
   logic [BCD_W-1:0] bcd_ff;
   logic [BCD_W-1:0] adj_in;
   logic [4:0]       cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < BCD_W / 4; d++) begin
         adj_in[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ? bcd_ff[d*4 +: 4] + 4'd3
                                                        : bcd_ff[d*4 +: 4];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(BIN_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff <= bin;
         bcd_ff <= '0;
      end else if (busy_ff) begin
         bin_ff <= {bin_ff[BIN_W-2:0], 1'b0};
         bcd_ff <= {adj_in[BCD_W-2:0], bin_ff[BIN_W-1]};
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

[hdl/integer_to_ascii_formatter_top.sv]
// integer to ascii formatter top level: command decode, digit shifter and output register
//
//  channel    dir  handshake       payload
//  req_chan   in   valid / ready   command[2:0], value[63:0]
//  rsp_chan   out  valid / ready   character[7:0], last_char, total_count[31:0]
//
// one item at a time; req_chan.ready is high only between items
// decimal: the value goes through the shift and add-3 converter; hex and pointer load at the accept
// then leading zero digits are dropped one at a time, keeping at least one (up to 9 decimal, 7 or 15
// hex); a null pointer goes straight to its text
// then the characters (at most 18) are emitted through the output register as it drains
// reset clears the control state and the running count; rsp_chan stalls only hold emission
module integer_to_ascii_formatter_top import itoa_pkg::*; (
   input logic      clock,
   input logic      reset,
   itoa_req_if.sink   req_chan,
   itoa_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_SKIP,
      S_PRE,
      S_DIG
   } state_type;

   state_type          state_ff;
   pre_type            pre_ff;
   logic [2:0]         pre_idx_ff;
   logic               upper_ff;
   logic [VALUE_W-1:0] digits_ff;
   logic [4:0]         ndig_ff;
   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic               last_ff;
   logic [COUNT_W-1:0] count_ff;

   logic               req_beat;
   logic               slot_free;
   logic               emit;
   logic               bcd_start;
   logic [BIN_W-1:0]   bcd_bin;
   logic               bcd_done;
   logic [BCD_W-1:0]   bcd_val;
   logic [BIN_W-1:0]   low_word;
   cmd_type            cmd;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign emit           = slot_free && (state_ff == S_PRE || state_ff == S_DIG);
   assign low_word       = req_chan.value[BIN_W-1:0];
   assign cmd            = cmd_type'(req_chan.command);

   // decimal magnitude into the converter
   assign bcd_start = req_beat && (cmd == CMD_SDEC || cmd == CMD_UDEC);
   assign bcd_bin   = (cmd == CMD_SDEC && low_word[BIN_W-1]) ? (~low_word + 32'd1) : low_word;

   itoa_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (bcd_start),
      .bin   (bcd_bin),
      .done  (bcd_done),
      .bcd   (bcd_val)
   );

   // sequencer, digit shifter and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         pre_ff       <= PRE_NONE;
         pre_idx_ff   <= '0;
         ndig_ff      <= '0;
      end else begin
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  pre_idx_ff <= '0;
                  case (cmd) inside
                     CMD_SDEC, CMD_UDEC: begin
                        pre_ff   <= (cmd == CMD_SDEC && low_word[BIN_W-1]) ? PRE_MINUS
                                                                            : PRE_NONE;
                        upper_ff <= 1'b0;
                        state_ff <= S_CONV;
                     end
                     CMD_HEXL, CMD_HEXU: begin
                        pre_ff    <= PRE_NONE;
                        upper_ff  <= (cmd == CMD_HEXU);
                        digits_ff <= {low_word, 32'd0};
                        ndig_ff   <= 5'd8;
                        state_ff  <= S_SKIP;
                     end
                     CMD_PTR: begin
                        upper_ff  <= 1'b0;
                        digits_ff <= req_chan.value;
                        ndig_ff   <= 5'd16;
                        if (req_chan.value == '0) begin
                           pre_ff   <= PRE_NIL;
                           state_ff <= S_PRE;
                        end else begin
                           pre_ff   <= PRE_HEX;
                           state_ff <= S_SKIP;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_CONV: begin
               if (bcd_done) begin
                  digits_ff <= {bcd_val, 24'd0};
                  ndig_ff   <= 5'd10;
                  state_ff  <= S_SKIP;
               end
            end
            S_SKIP: begin
               // drop leading zero digits, keep at least one
               if (digits_ff[VALUE_W-1 -: 4] == 4'd0 && ndig_ff > 5'd1) begin
                  digits_ff <= {digits_ff[VALUE_W-5:0], 4'd0};
                  ndig_ff   <= ndig_ff - 5'd1;
               end else begin
                  state_ff <= (pre_ff == PRE_NONE) ? S_DIG : S_PRE;
               end
            end
            S_PRE: begin
               if (slot_free) begin
                  char_ff      <= prefix_char(pre_ff, pre_idx_ff);
                  last_ff      <= (pre_ff == PRE_NIL) && (pre_idx_ff == prefix_last(pre_ff));
                  count_ff     <= count_ff + 32'd1;
                  pre_idx_ff   <= pre_idx_ff + 3'd1;
                  if (pre_idx_ff == prefix_last(pre_ff)) begin
                     state_ff <= (pre_ff == PRE_NIL) ? S_IDLE : S_DIG;
                  end
               end
            end
            S_DIG: begin
               if (slot_free) begin
                  char_ff      <= digit_char(digits_ff[VALUE_W-1 -: 4], upper_ff);
                  last_ff      <= (ndig_ff == 5'd1);
                  count_ff     <= count_ff + 32'd1;
                  digits_ff    <= {digits_ff[VALUE_W-5:0], 4'd0};
                  ndig_ff      <= ndig_ff - 5'd1;
                  if (ndig_ff == 5'd1) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.character   = char_ff;
   assign rsp_chan.last_char   = last_ff;
   assign rsp_chan.total_count = count_ff;

endmodule
